[src/tfpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tfpt_pkg;

    localparam int ADDR_W  = 16;
    localparam int FRAME_W = 9;
    localparam int COUNT_W = 32;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int PAGE_BYTES_DEF  = 256;

    // one page map entry: mapped flag plus frame number
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } pm_entry_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } tlb_result_t;

endpackage

`default_nettype wire

[src/tfpt_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tfpt_addr_if;
    logic                       valid;
    logic                       ready;
    logic [tfpt_pkg::ADDR_W-1:0] logical_address;

    modport source (output valid, output logical_address, input ready);
    modport sink   (input valid, input logical_address, output ready);
endinterface

interface tfpt_xlat_if;
    logic                        valid;
    logic                        ready;
    logic [tfpt_pkg::ADDR_W-1:0]  physical_address;
    logic                        tlb_hit;
    logic                        page_fault;
    logic [tfpt_pkg::COUNT_W-1:0] hit_total;
    logic [tfpt_pkg::COUNT_W-1:0] fault_total;

    modport source (output valid, output physical_address, output tlb_hit,
                    output page_fault, output hit_total, output fault_total,
                    input ready);
    modport sink   (input valid, input physical_address, input tlb_hit,
                    input page_fault, input hit_total, input fault_total,
                    output ready);
endinterface

`default_nettype wire

[src/tfpt_page_map.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfpt_page_map #(
    parameter int PAGE_COUNT = tfpt_pkg::PAGE_COUNT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(PAGE_COUNT)-1:0]     rd_page,
    output tfpt_pkg::pm_entry_t                    rd_entry,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(PAGE_COUNT)-1:0]     wr_page,
    input  wire tfpt_pkg::pm_entry_t               wr_entry,
    output logic                                   clearing
);

    localparam int PAGE_W = $clog2(PAGE_COUNT);

    tfpt_pkg::pm_entry_t mem [PAGE_COUNT];
    tfpt_pkg::pm_entry_t rd_entry_reg;
    logic                clearing_reg;
    logic [PAGE_W-1:0]   clr_cnt_reg;

    // sweep after reset marks every page unmapped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == PAGE_W'(PAGE_COUNT - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_page] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_page];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

[src/tfpt_tlb.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfpt_tlb #(
    parameter int TLB_ENTRIES = tfpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_W      = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [PAGE_W-1:0]               lookup_page,
    output tfpt_pkg::tlb_result_t                lookup,
    input  wire logic                            push_en,
    input  wire logic [PAGE_W-1:0]               push_page,
    input  wire logic [tfpt_pkg::FRAME_W-1:0]    push_frame
);

    logic [TLB_ENTRIES-1:0]        valid_reg;
    logic [TLB_ENTRIES-1:0]        valid_next;
    logic [PAGE_W-1:0]             tag_reg   [TLB_ENTRIES];
    logic [tfpt_pkg::FRAME_W-1:0]  frame_reg [TLB_ENTRIES];

    // slot 0 is newest; the highest matching slot is the oldest and wins
    always_comb
    begin
        lookup = '0;
        for (int k = 0; k < TLB_ENTRIES; k++)
        begin
            if (valid_reg[k] && (tag_reg[k] == lookup_page))
            begin
                lookup.hit   = 1'b1;
                lookup.frame = frame_reg[k];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (push_en)
        begin
            valid_next[0] = 1'b1;
            for (int k = 1; k < TLB_ENTRIES; k++)
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // fifo insert at the front, oldest slot falls off the end
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            tag_reg[0]   <= push_page;
            frame_reg[0] <= push_frame;
            for (int k = 1; k < TLB_ENTRIES; k++)
            begin
                tag_reg[k]   <= tag_reg[k-1];
                frame_reg[k] <= frame_reg[k-1];
            end
        end
    end

endmodule

`default_nettype wire

[src/tlb_fifo_page_translator.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | payload
// request  | in  | logical_address[15:0]
// result   | out | physical_address[15:0], tlb_hit, page_fault,
//          |     | hit_total[31:0], fault_total[31:0]
//
// one address per cycle sustained while no result is held at the output; an
// accepted request passes through the input register, the page map memory read,
// then the tlb lookup into the result register.
// after reset the page map is swept unmapped, one entry a cycle, through all
// PAGE_COUNT entries; request.ready stays low during the sweep.
// a result held at the output stalls the whole pipeline and drops request.ready.
// PAGE_BYTES must be a power of two; the block itself does not enforce this.

module tlb_fifo_page_translator #(
    parameter int TLB_ENTRIES = tfpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tfpt_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_BYTES  = tfpt_pkg::PAGE_BYTES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    tfpt_addr_if.sink         request,
    tfpt_xlat_if.source       result
);

    localparam int ADDR_W    = tfpt_pkg::ADDR_W;
    localparam int FRAME_W   = tfpt_pkg::FRAME_W;
    localparam int COUNT_W   = tfpt_pkg::COUNT_W;
    localparam int OFFSET_W  = $clog2(PAGE_BYTES);
    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int RAW_W     = ADDR_W - OFFSET_W;
    localparam int MOD_STEPS = (RAW_W - PAGE_W + 1 > 0) ? (RAW_W - PAGE_W + 1) : 0;

    logic                  advance;
    logic                  clearing;

    logic                  a_valid_reg;
    logic [ADDR_W-1:0]     a_addr_reg;
    logic [RAW_W-1:0]      a_rem;
    logic [PAGE_W-1:0]     a_page;

    logic                  b_valid_reg;
    logic [PAGE_W-1:0]     b_page_reg;
    logic [OFFSET_W-1:0]   b_offset_reg;

    tfpt_pkg::pm_entry_t   pm_rd;
    tfpt_pkg::pm_entry_t   pm_cur;
    tfpt_pkg::pm_entry_t   pm_wr;
    tfpt_pkg::tlb_result_t tlb_res;

    logic                  fwd_valid_reg;
    logic [PAGE_W-1:0]     fwd_page_reg;
    logic [FRAME_W-1:0]    fwd_frame_reg;

    logic [FRAME_W-1:0]    free_frame_reg;
    logic [COUNT_W-1:0]    hit_cnt_reg;
    logic [COUNT_W-1:0]    fault_cnt_reg;

    logic                  b_fault;
    logic [FRAME_W-1:0]    b_frame;
    logic                  b_update;
    logic [COUNT_W-1:0]    hit_cnt_next;
    logic [COUNT_W-1:0]    fault_cnt_next;

    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     out_phys_reg;
    logic                  out_hit_reg;
    logic                  out_fault_reg;
    logic [COUNT_W-1:0]    out_hits_reg;
    logic [COUNT_W-1:0]    out_faults_reg;

    assign advance       = !out_valid_reg || result.ready;
    assign request.ready = advance && !clearing;

    // page number modulo PAGE_COUNT by subtracting shifted multiples
    always_comb
    begin
        a_rem = a_addr_reg[ADDR_W-1:OFFSET_W];
        for (int j = MOD_STEPS - 1; j >= 0; j--)
        begin
            if (32'(a_rem) >= (32'(PAGE_COUNT) << j))
            begin
                a_rem = a_rem - RAW_W'(32'(PAGE_COUNT) << j);
            end
        end
        a_page = PAGE_W'(a_rem);
    end

    tfpt_page_map #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_page_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (advance),
        .rd_page  (a_page),
        .rd_entry (pm_rd),
        .wr_en    (b_update && b_fault),
        .wr_page  (b_page_reg),
        .wr_entry (pm_wr),
        .clearing (clearing)
    );

    tfpt_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_W      (PAGE_W)
    ) u_tlb (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_page (b_page_reg),
        .lookup      (tlb_res),
        .push_en     (b_update && b_fault),
        .push_page   (b_page_reg),
        .push_frame  (free_frame_reg)
    );

    // the memory read raced the previous fault's write-back: take it from the bypass
    always_comb
    begin
        pm_cur = pm_rd;
        if (fwd_valid_reg && (fwd_page_reg == b_page_reg))
        begin
            pm_cur.valid = 1'b1;
            pm_cur.frame = fwd_frame_reg;
        end
    end

    always_comb
    begin
        b_fault        = !tlb_res.hit && !pm_cur.valid;
        b_update       = advance && b_valid_reg;
        pm_wr.valid    = 1'b1;
        pm_wr.frame    = free_frame_reg;
        hit_cnt_next   = hit_cnt_reg + COUNT_W'(tlb_res.hit);
        fault_cnt_next = fault_cnt_reg + COUNT_W'(b_fault);
        if (tlb_res.hit)
        begin
            b_frame = tlb_res.frame;
        end
        else if (b_fault)
        begin
            b_frame = free_frame_reg;
        end
        else
        begin
            b_frame = pm_cur.frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            free_frame_reg <= '0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
        end
        else if (advance)
        begin
            a_valid_reg   <= request.valid && !clearing;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
            fwd_valid_reg <= b_valid_reg && b_fault;
            if (b_valid_reg)
            begin
                hit_cnt_reg   <= hit_cnt_next;
                fault_cnt_reg <= fault_cnt_next;
                if (b_fault)
                begin
                    free_frame_reg <= free_frame_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_addr_reg     <= request.logical_address;
            b_page_reg     <= a_page;
            b_offset_reg   <= a_addr_reg[OFFSET_W-1:0];
            fwd_page_reg   <= b_page_reg;
            fwd_frame_reg  <= free_frame_reg;
            out_phys_reg   <= ADDR_W'({b_frame, b_offset_reg});
            out_hit_reg    <= tlb_res.hit;
            out_fault_reg  <= b_fault;
            out_hits_reg   <= hit_cnt_next;
            out_faults_reg <= fault_cnt_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.physical_address = out_phys_reg;
    assign result.tlb_hit          = out_hit_reg;
    assign result.page_fault       = out_fault_reg;
    assign result.hit_total        = out_hits_reg;
    assign result.fault_total      = out_faults_reg;

endmodule

`default_nettype wire
